// ----- rtl/nps_pkg.sv -----
// Shared widths, job record types and the scheduler's state encoding.
`default_nettype none
package nps_pkg;

  localparam int MaxProcs = 16;
  localparam int IdW      = 8;
  localparam int PrioW    = 8;
  localparam int BurstW   = 12;
  localparam int ArrW     = 12;
  localparam int OutTimeW = 17;
  localparam int SumW     = 21;
  // Internal time must hold the latest possible completion without wrapping.
  localparam int TimeW    = $clog2(MaxProcs * 4096 + 4096);
  localparam int IdxW     = $clog2(MaxProcs);
  localparam int CntW     = $clog2(MaxProcs + 1);

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] burst;
    logic [ArrW-1:0]   arr;
  } job_t;

  typedef struct packed {
    logic valid;
    logic done;
    job_t job;
  } cell_t;

  typedef struct packed {
    logic            ready;
    logic [IdxW-1:0] idx;
    job_t            job;
  } pick_t;

  typedef enum logic [2:0] {
    StLoad = 3'b001,
    StScan = 3'b010,
    StSel  = 3'b100
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/nonpreemptive_priority_scheduler.sv -----
// Top level: record loading, job ring, selection and result register.
// Job records load one beat per cycle into a ring of MaxProcs cells; a record
// past capacity is dropped and flags the batch as overflowed. The beat marked
// last starts the schedule. For each result the ring rotates once past the
// head comparator, cell by cell, then the select state picks the winner and
// computes its times once the result register is free. The next rotation runs
// while a result waits to be taken. After the last result the block is empty
// and takes a new batch; no input beat is taken while a batch is scheduled.
`default_nettype none
module nonpreemptive_priority_scheduler (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [nps_pkg::IdW-1:0]       proc_id_i,
  input  wire logic [nps_pkg::PrioW-1:0]     priority_level_i,
  input  wire logic [nps_pkg::BurstW-1:0]    burst_time_i,
  input  wire logic [nps_pkg::ArrW-1:0]      arrival_time_i,
  input  wire logic                          last_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [nps_pkg::IdW-1:0]            proc_id_out_o,
  output logic [nps_pkg::OutTimeW-1:0]       start_time_o,
  output logic [nps_pkg::OutTimeW-1:0]       completion_time_o,
  output logic [nps_pkg::OutTimeW-1:0]       waiting_time_o,
  output logic [nps_pkg::OutTimeW-1:0]       turnaround_time_o,
  output logic [nps_pkg::SumW-1:0]           sum_completion_o,
  output logic [nps_pkg::SumW-1:0]           sum_waiting_o,
  output logic [nps_pkg::SumW-1:0]           sum_turnaround_o,
  output logic                               overflowed_o,
  output logic                               last_result_o
);

  localparam int MaxProcs = nps_pkg::MaxProcs;
  localparam int TimeW    = nps_pkg::TimeW;
  localparam int IdxW     = nps_pkg::IdxW;
  localparam int CntW     = nps_pkg::CntW;
  localparam int SumW     = nps_pkg::SumW;
  localparam int OutTimeW = nps_pkg::OutTimeW;

  nps_pkg::state_e       state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d, emit_q, emit_d;
  logic                  ovf_q, ovf_d;
  logic [TimeW-1:0]      time_q, time_d;
  logic [IdxW-1:0]       scan_q, scan_d;
  logic [SumW-1:0]       sc_q, sc_d, sw_q, sw_d, st_q, st_d;
  logic                  out_valid_q, out_valid_d;

  logic                  in_acc, room, sel_go, is_last, scanning;
  nps_pkg::job_t         in_job;
  nps_pkg::pick_t        pick;
  nps_pkg::cell_t        cells [MaxProcs];
  logic [TimeW-1:0]      start_t, comp_t, wait_t, tat_t;

  assign in_ready_o = (state_q == nps_pkg::StLoad);
  assign in_acc     = in_valid_i && in_ready_o;
  assign room       = cnt_q < CntW'(MaxProcs);
  assign scanning   = (state_q == nps_pkg::StScan);
  assign sel_go     = (state_q == nps_pkg::StSel) && (!out_valid_q || out_ready_i);
  assign is_last    = (CntW'(emit_q + CntW'(1)) == cnt_q);

  assign in_job = '{id: proc_id_i, prio: priority_level_i,
                    burst: burst_time_i, arr: arrival_time_i};

  // Ring: each cell takes its upper neighbor, the head wraps to the tail.
  for (genvar k = 0; k < MaxProcs; k++) begin : g_cell
    nps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (sel_go && is_last),
      .load_i     (in_acc && room && (cnt_q == CntW'(k))),
      .load_job_i (in_job),
      .shift_i    (scanning),
      .mark_i     (sel_go && (pick.idx == IdxW'(k))),
      .nbr_i      (cells[(k + 1) % MaxProcs]),
      .cell_o     (cells[k])
    );
  end

  nps_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (scanning),
    .first_i (scan_q == '0),
    .idx_i   (scan_q),
    .time_i  (time_q),
    .head_i  (cells[0]),
    .pick_o  (pick)
  );

  // With nothing ready, jump across the idle gap to the earliest arrival.
  assign start_t = pick.ready ? time_q : TimeW'(pick.job.arr);
  assign comp_t  = start_t + TimeW'(pick.job.burst);
  assign wait_t  = start_t - TimeW'(pick.job.arr);
  assign tat_t   = comp_t - TimeW'(pick.job.arr);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    emit_d      = emit_q;
    ovf_d       = ovf_q;
    time_d      = time_q;
    scan_d      = scan_q;
    sc_d        = sc_q;
    sw_d        = sw_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      nps_pkg::StLoad: begin
        if (in_acc) begin
          if (room) begin
            cnt_d = CntW'(cnt_q + CntW'(1));
          end else begin
            ovf_d = 1'b1;
          end
          if (last_item_i) begin
            state_d = nps_pkg::StScan;
            scan_d  = '0;
          end
        end
      end
      nps_pkg::StScan: begin
        scan_d = IdxW'(scan_q + IdxW'(1));
        if (scan_q == IdxW'(MaxProcs - 1)) begin
          state_d = nps_pkg::StSel;
        end
      end
      nps_pkg::StSel: begin
        if (sel_go) begin
          out_valid_d = 1'b1;
          if (is_last) begin
            state_d = nps_pkg::StLoad;
            cnt_d   = '0;
            emit_d  = '0;
            ovf_d   = 1'b0;
            time_d  = '0;
            sc_d    = '0;
            sw_d    = '0;
            st_d    = '0;
          end else begin
            state_d = nps_pkg::StScan;
            scan_d  = '0;
            emit_d  = CntW'(emit_q + CntW'(1));
            time_d  = comp_t;
            sc_d    = SumW'(sc_q + SumW'(comp_t));
            sw_d    = SumW'(sw_q + SumW'(wait_t));
            st_d    = SumW'(st_q + SumW'(tat_t));
          end
        end
      end
      default: state_d = nps_pkg::StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nps_pkg::StLoad;
      cnt_q       <= '0;
      emit_q      <= '0;
      ovf_q       <= 1'b0;
      time_q      <= '0;
      scan_q      <= '0;
      sc_q        <= '0;
      sw_q        <= '0;
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      emit_q      <= emit_d;
      ovf_q       <= ovf_d;
      time_q      <= time_d;
      scan_q      <= scan_d;
      sc_q        <= sc_d;
      sw_q        <= sw_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register: load a beat when the winner is taken.
  always_ff @(posedge clk_i) begin
    if (sel_go) begin
      proc_id_out_o     <= pick.job.id;
      start_time_o      <= OutTimeW'(start_t);
      completion_time_o <= OutTimeW'(comp_t);
      waiting_time_o    <= OutTimeW'(wait_t);
      turnaround_time_o <= OutTimeW'(tat_t);
      sum_completion_o  <= SumW'(sc_q + SumW'(comp_t));
      sum_waiting_o     <= SumW'(sw_q + SumW'(wait_t));
      sum_turnaround_o  <= SumW'(st_q + SumW'(tat_t));
      overflowed_o      <= ovf_q;
      last_result_o     <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/nps_cell.sv -----
// One slot of the job ring: holds a record and passes it to its neighbor.
`default_nettype none
module nps_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clear_i,
  input  wire logic          load_i,
  input  wire nps_pkg::job_t load_job_i,
  input  wire logic          shift_i,
  input  wire logic          mark_i,
  input  wire nps_pkg::cell_t nbr_i,
  output nps_pkg::cell_t     cell_o
);

  logic          valid_q, valid_d;
  logic          done_q, done_d;
  nps_pkg::job_t job_q, job_d;

  always_comb begin
    valid_d = valid_q;
    done_d  = done_q;
    job_d   = job_q;
    priority if (clear_i) begin
      valid_d = 1'b0;
      done_d  = 1'b0;
    end else if (load_i) begin
      valid_d = 1'b1;
      done_d  = 1'b0;
      job_d   = load_job_i;
    end else if (shift_i) begin
      valid_d = nbr_i.valid;
      done_d  = nbr_i.done;
      job_d   = nbr_i.job;
    end else if (mark_i) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign cell_o = '{valid: valid_q, done: done_q, job: job_q};

endmodule
`default_nettype wire

// ----- rtl/nps_pick.sv -----
// Comparator at the ring head: tracks the best ready job and the earliest future job.
`default_nettype none
module nps_pick (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic                         first_i,
  input  wire logic [nps_pkg::IdxW-1:0]     idx_i,
  input  wire logic [nps_pkg::TimeW-1:0]    time_i,
  input  wire nps_pkg::cell_t               head_i,
  output nps_pkg::pick_t                    pick_o
);

  logic                     rdy_found_q, rdy_found_d;
  logic                     fut_found_q, fut_found_d;
  nps_pkg::job_t            rdy_job_q, rdy_job_d, fut_job_q, fut_job_d;
  logic [nps_pkg::IdxW-1:0] rdy_idx_q, rdy_idx_d, fut_idx_q, fut_idx_d;
  logic                     cand, is_ready, rdy_better, fut_better;

  assign cand     = head_i.valid && !head_i.done;
  assign is_ready = nps_pkg::TimeW'(head_i.job.arr) <= time_i;

  // Strict compares keep the earlier load position on full ties.
  assign rdy_better = !rdy_found_d ||
                      (head_i.job.prio < rdy_job_q.prio) ||
                      ((head_i.job.prio == rdy_job_q.prio) &&
                       (head_i.job.arr < rdy_job_q.arr));
  assign fut_better = !fut_found_d ||
                      (head_i.job.arr < fut_job_q.arr) ||
                      ((head_i.job.arr == fut_job_q.arr) &&
                       (head_i.job.prio < fut_job_q.prio));

  always_comb begin
    rdy_found_d = first_i ? 1'b0 : rdy_found_q;
    fut_found_d = first_i ? 1'b0 : fut_found_q;
    rdy_job_d   = rdy_job_q;
    fut_job_d   = fut_job_q;
    rdy_idx_d   = rdy_idx_q;
    fut_idx_d   = fut_idx_q;
    if (cand && is_ready && rdy_better) begin
      rdy_job_d = head_i.job;
      rdy_idx_d = idx_i;
    end
    if (cand && !is_ready && fut_better) begin
      fut_job_d = head_i.job;
      fut_idx_d = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_found_q <= 1'b0;
      fut_found_q <= 1'b0;
    end else if (step_i) begin
      rdy_found_q <= rdy_found_d || (cand && is_ready);
      fut_found_q <= fut_found_d || (cand && !is_ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      rdy_job_q <= rdy_job_d;
      fut_job_q <= fut_job_d;
      rdy_idx_q <= rdy_idx_d;
      fut_idx_q <= fut_idx_d;
    end
  end

  assign pick_o.ready = rdy_found_q;
  assign pick_o.idx   = rdy_found_q ? rdy_idx_q : fut_idx_q;
  assign pick_o.job   = rdy_found_q ? rdy_job_q : fut_job_q;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the nonpreemptive priority scheduler.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxProcs   = nps_pkg::MaxProcs;
  localparam int IdW        = nps_pkg::IdW;
  localparam int PrioW      = nps_pkg::PrioW;
  localparam int BurstW     = nps_pkg::BurstW;
  localparam int ArrW       = nps_pkg::ArrW;
  localparam int OutTimeW   = nps_pkg::OutTimeW;
  localparam int SumW       = nps_pkg::SumW;
  localparam int QuietLimit = 4000;
  localparam int HoldCycles = 400;
  localparam int TailCycles = 2 * (MaxProcs + 1) + 8;

  typedef nps_pkg::job_t job_t;

  typedef struct packed {
    job_t job;
    logic last;
  } rec_t;

  typedef struct {
    logic [IdW-1:0]      id;
    logic [OutTimeW-1:0] start_tk;
    logic [OutTimeW-1:0] done_tk;
    logic [OutTimeW-1:0] wait_tk;
    logic [OutTimeW-1:0] tat_tk;
    logic [SumW-1:0]     sum_done;
    logic [SumW-1:0]     sum_wait;
    logic [SumW-1:0]     sum_tat;
    logic                ovf;
    logic                last;
  } slot_t;

  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic [IdW-1:0]      proc_id_i        = '0;
  logic [PrioW-1:0]    priority_level_i = '0;
  logic [BurstW-1:0]   burst_time_i     = '0;
  logic [ArrW-1:0]     arrival_time_i   = '0;
  logic                last_item_i      = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [IdW-1:0]      proc_id_out_o;
  logic [OutTimeW-1:0] start_time_o;
  logic [OutTimeW-1:0] completion_time_o;
  logic [OutTimeW-1:0] waiting_time_o;
  logic [OutTimeW-1:0] turnaround_time_o;
  logic [SumW-1:0]     sum_completion_o;
  logic [SumW-1:0]     sum_waiting_o;
  logic [SumW-1:0]     sum_turnaround_o;
  logic                overflowed_o;
  logic                last_result_o;

  nonpreemptive_priority_scheduler i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .proc_id_i         (proc_id_i),
    .priority_level_i  (priority_level_i),
    .burst_time_i      (burst_time_i),
    .arrival_time_i    (arrival_time_i),
    .last_item_i       (last_item_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .proc_id_out_o     (proc_id_out_o),
    .start_time_o      (start_time_o),
    .completion_time_o (completion_time_o),
    .waiting_time_o    (waiting_time_o),
    .turnaround_time_o (turnaround_time_o),
    .sum_completion_o  (sum_completion_o),
    .sum_waiting_o     (sum_waiting_o),
    .sum_turnaround_o  (sum_turnaround_o),
    .overflowed_o      (overflowed_o),
    .last_result_o     (last_result_o)
  );

  rec_t  job_backlog[$];
  slot_t expected_slots[$];

  // Predictor copy of the job store.
  job_t  held_jobs [MaxProcs];
  bit    held_done [MaxProcs];
  int    held_cnt = 0;
  bit    held_ovf = 1'b0;

  int    recs_total    = 0;
  int    recs_sent     = 0;
  int    batches       = 0;
  int    ovf_batches   = 0;
  int    slots_checked = 0;
  int    err_cnt       = 0;
  int    hold_left     = 0;
  bit    held_once     = 1'b0;
  int    quiet_cycles  = 0;
  logic  steady        = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void queue_rec(int id, int prio, int burst, int arr, bit last);
    rec_t r;
    r.job.id    = id[IdW-1:0];
    r.job.prio  = prio[PrioW-1:0];
    r.job.burst = burst[BurstW-1:0];
    r.job.arr   = arr[ArrW-1:0];
    r.last      = last;
    job_backlog.insert(job_backlog.size(), r);
    recs_total++;
  endfunction

  // Store one record; on the last mark, run the whole batch and queue its slots.
  task automatic load_record(job_t rec, logic last);
    int    k;
    int    i;
    int    cur_t;
    int    min_arr;
    int    best;
    int    t_done;
    int    t_wait;
    int    t_tat;
    int    s_done;
    int    s_wait;
    int    s_tat;
    bit    found;
    bit    any_left;
    slot_t s;
    if (held_cnt < MaxProcs) begin
      held_jobs[held_cnt] = rec;
      held_done[held_cnt] = 1'b0;
      held_cnt++;
    end else begin
      held_ovf = 1'b1;
    end
    if (last) begin
      cur_t  = 0;
      s_done = 0;
      s_wait = 0;
      s_tat  = 0;
      for (k = 0; k < held_cnt; k++) begin
        any_left = 1'b0;
        min_arr  = 0;
        for (i = 0; i < held_cnt; i++) begin
          if (!held_done[i] && (!any_left || int'(held_jobs[i].arr) < min_arr)) begin
            min_arr  = int'(held_jobs[i].arr);
            any_left = 1'b1;
          end
        end
        // jump over an idle gap
        if (min_arr > cur_t) cur_t = min_arr;
        found = 1'b0;
        best  = 0;
        for (i = 0; i < held_cnt; i++) begin
          if (!held_done[i] && int'(held_jobs[i].arr) <= cur_t) begin
            if (!found || held_jobs[i].prio < held_jobs[best].prio ||
                (held_jobs[i].prio == held_jobs[best].prio &&
                 held_jobs[i].arr < held_jobs[best].arr)) begin
              best  = i;
              found = 1'b1;
            end
          end
        end
        held_done[best] = 1'b1;
        t_done = cur_t + int'(held_jobs[best].burst);
        t_wait = cur_t - int'(held_jobs[best].arr);
        t_tat  = t_done - int'(held_jobs[best].arr);
        s_done += t_done;
        s_wait += t_wait;
        s_tat  += t_tat;
        s.id       = held_jobs[best].id;
        s.start_tk = cur_t[OutTimeW-1:0];
        s.done_tk  = t_done[OutTimeW-1:0];
        s.wait_tk  = t_wait[OutTimeW-1:0];
        s.tat_tk   = t_tat[OutTimeW-1:0];
        s.sum_done = s_done[SumW-1:0];
        s.sum_wait = s_wait[SumW-1:0];
        s.sum_tat  = s_tat[SumW-1:0];
        s.ovf      = held_ovf;
        s.last     = (k == held_cnt - 1);
        expected_slots.insert(expected_slots.size(), s);
        cur_t = t_done;
      end
      batches++;
      if (held_ovf) ovf_batches++;
      held_cnt = 0;
      held_ovf = 1'b0;
    end
  endtask

  task automatic check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
      err_cnt++;
    end
  endtask

  // Driver: hold each beat until taken, then offer the next or idle.
  always @(posedge clk_i) begin : drive_p
    job_t beat_job;
    rec_t nxt;
    bit   fire;
    if (rst_ni) begin
      fire = in_valid_i && in_ready_o;
      if (fire) begin
        beat_job.id    = proc_id_i;
        beat_job.prio  = priority_level_i;
        beat_job.burst = burst_time_i;
        beat_job.arr   = arrival_time_i;
        load_record(beat_job, last_item_i);
        recs_sent++;
      end
      steady <= (recs_sent >= 110 && recs_sent < 170);
      if (!in_valid_i || fire) begin
        if (job_backlog.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
          nxt = job_backlog.pop_front();
          proc_id_i        <= nxt.job.id;
          priority_level_i <= nxt.job.prio;
          burst_time_i     <= nxt.job.burst;
          arrival_time_i   <= nxt.job.arr;
          last_item_i      <= nxt.last;
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expected slot.
  always @(posedge clk_i) begin : watch_p
    slot_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        slots_checked++;
        if (expected_slots.size() == 0) begin
          $display("%t: result beat with nothing expected: expected none, actual id %0d",
                   $time, proc_id_out_o);
          err_cnt++;
        end else begin
          want = expected_slots.pop_front();
          check_field("proc_id_out",     32'(want.id),       32'(proc_id_out_o));
          check_field("start_time",      32'(want.start_tk), 32'(start_time_o));
          check_field("completion_time", 32'(want.done_tk),  32'(completion_time_o));
          check_field("waiting_time",    32'(want.wait_tk),  32'(waiting_time_o));
          check_field("turnaround_time", 32'(want.tat_tk),   32'(turnaround_time_o));
          check_field("sum_completion",  32'(want.sum_done), 32'(sum_completion_o));
          check_field("sum_waiting",     32'(want.sum_wait), 32'(sum_waiting_o));
          check_field("sum_turnaround",  32'(want.sum_tat),  32'(sum_turnaround_o));
          check_field("overflowed",      32'(want.ovf),      32'(overflowed_o));
          check_field("last_result",     32'(want.last),     32'(last_result_o));
        end
      end
      // Hold off once for a long stretch so the block backs up into its input.
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held_once && slots_checked >= 60 && out_valid_o) begin
        held_once = 1'b1;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || $urandom_range(99) >= 18;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("%t: no beat accepted for %0d cycles", $time, QuietLimit);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim_p
    int n;
    int j;
    int mode;
    // single job at time zero, all fields zero
    queue_rec(0, 0, 0, 0, 1'b1);
    // single job at the top of every field, idle until it arrives
    queue_rec(255, 255, 4095, 4095, 1'b1);
    // arrival tie-break, load-order tie-break, arrival at now, late gap
    queue_rec(1, 5, 10, 0, 1'b0);
    queue_rec(2, 3, 5, 10, 1'b0);
    queue_rec(3, 3, 5, 10, 1'b0);
    queue_rec(5, 3, 1, 5, 1'b0);
    queue_rec(4, 1, 2, 100, 1'b1);
    // full store, then a dropped record that carries the last mark
    for (j = 0; j <= MaxProcs; j++) begin
      queue_rec($urandom_range(255), $urandom_range(3), $urandom_range(20),
                $urandom_range(60), j == MaxProcs);
    end
    while (recs_total < 230) begin
      mode = $urandom_range(2);
      n = ($urandom_range(9) == 0) ? $urandom_range(MaxProcs + 4, MaxProcs + 1)
                                   : $urandom_range(MaxProcs, 1);
      for (j = 0; j < n; j++) begin
        case (mode)
          0: queue_rec($urandom_range(255), $urandom_range(3), $urandom_range(8),
                       $urandom_range(40), j == n - 1);
          1: queue_rec($urandom_range(255), $urandom_range(255), $urandom_range(4095),
                       $urandom_range(4095), j == n - 1);
          default: queue_rec($urandom_range(255), $urandom_range(15), $urandom_range(300),
                             $urandom_range(4095), j == n - 1);
        endcase
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (recs_sent != recs_total) @(posedge clk_i);
    while (expected_slots.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("tb_top: %0d job records in %0d batches (%0d with dropped records)",
             recs_total, batches, ovf_batches);
    $display("tb_top: %0d scheduled results checked, %0d mismatches", slots_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
